@@ rtl/cdu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdu_pkg
// Shared types, constants and calendar tables for the civil date to Unix
// seconds converter.
// ----------------------------------------------------------------------------
package cdu_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    localparam int K_W      = 9;   // years since 1600, March-based
    localparam int DOY_W    = 9;   // day of March-based year
    localparam int SUM_W    = 18;  // day count before wrap to DAYS_W
    localparam int DAYS_W   = 16;  // days since epoch, max 49710
    localparam int TOD_W    = 17;  // seconds of day
    localparam int SECS_W   = 32;
    localparam int STAMP_W  = MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;

    localparam logic [YEAR_W-1:0]   YEAR_MIN     = 12'd1970;
    localparam logic [YEAR_W-1:0]   YEAR_MAX     = 12'd2106;
    localparam logic [YEAR_W-1:0]   YEAR_NO_LEAP = 12'd2100;
    localparam logic [YEAR_W-1:0]   BASE_YEAR    = 12'd1600;
    localparam logic [MONTH_W-1:0]  MONTH_JAN    = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_APR    = 4'd4;
    localparam logic [MONTH_W-1:0]  MONTH_JUN    = 4'd6;
    localparam logic [MONTH_W-1:0]  MONTH_SEP    = 4'd9;
    localparam logic [MONTH_W-1:0]  MONTH_NOV    = 4'd11;
    localparam logic [MONTH_W-1:0]  MONTH_DEC    = 4'd12;
    localparam logic [HOUR_W-1:0]   HOURS_PER_DAY   = 5'd24;
    localparam logic [MINUTE_W-1:0] MINS_PER_HOUR   = 6'd60;
    localparam logic [SECOND_W-1:0] SECS_PER_MIN    = 6'd60;

    // last representable moment: 2106-02-07 06:28:15
    localparam logic [STAMP_W-1:0] LIMIT_STAMP = {4'd2, 5'd7, 5'd6, 6'd28, 6'd15};

    // days from 1600-03-01 to 1970-01-01
    localparam logic [SUM_W-1:0]  EPOCH_OFFSET  = 18'd135080;
    localparam logic [SUM_W-1:0]  DAYS_PER_YEAR = 18'd365;
    localparam logic [K_W-1:0]    K_100 = 9'd100;
    localparam logic [K_W-1:0]    K_200 = 9'd200;
    localparam logic [K_W-1:0]    K_300 = 9'd300;
    localparam logic [K_W-1:0]    K_400 = 9'd400;
    localparam logic [K_W-1:0]    K_500 = 9'd500;
    localparam logic [TOD_W-1:0]  SECS_PER_HOUR = 17'd3600;
    localparam logic [TOD_W-1:0]  SECS_PER_MINUTE = 17'd60;
    localparam logic [SECS_W-1:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [DAYS_W-1:0] DAYS_MAX      = 16'd49710;
    localparam logic [K_W-1:0]    K_MIN         = 9'd369;
    localparam logic [K_W-1:0]    K_MAX         = 9'd506;

    typedef struct packed {
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } civil_t;

    typedef struct packed {
        logic                ok;
        logic [K_W-1:0]      k;
        logic [DOY_W-1:0]    doy;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } dec_t;

    typedef struct packed {
        logic              ok;
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } cnt_t;

    typedef struct packed {
        logic              ok;
        logic [SECS_W-1:0] secs;
    } res_t;

    // days before the month in a year that starts in March
    function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        unique case (m)
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] r;
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
            r = 5'd30;
        else if (m == MONTH_FEB)
            r = leap ? 5'd29 : 5'd28;
        else
            r = 5'd31;
        return r;
    endfunction

endpackage

@@ rtl/civil_datetime_to_unix_seconds_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_datetime_to_unix_seconds_core
// Converts a broken-down UTC date and time into the 32-bit Unix seconds count.
//
// Input stream (s_axis): one transfer carries year, month, day, hour, minute
// and second. Output stream (m_axis): one transfer per input, tdata holds the
// seconds since 1970-01-01 00:00:00, tuser is 1 when the date was accepted
// (years 1970 to 2106, real calendar day, time in range, not after
// 2106-02-07 06:28:15) and 0 otherwise, with tdata zero.
//
// Four register stages: check/decode, day count, multiply by 86400, final
// add. One transfer per cycle is sustained while m_axis_tready stays high,
// set by the single shared stage enable.
// When m_axis_tready is low while a result waits, the whole pipeline holds
// and s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module civil_datetime_to_unix_seconds_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
    // [31:26] minute, [37:32] second, [39:38] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] unix_seconds
    output logic [31:0] m_axis_tdata,
    // [0] valid_res
    output logic        m_axis_tuser
);

    logic              adv;
    cdu_pkg::civil_t   in_item;
    logic              dec_valid;
    cdu_pkg::dec_t     dec_item;
    logic              cnt_valid;
    cdu_pkg::cnt_t     cnt_item;
    logic              res_valid;
    cdu_pkg::res_t     res_item;

    // stages move together whenever the output slot is free or being drained
    assign adv           = !res_valid || m_axis_tready;
    assign s_axis_tready = adv;

    assign in_item = cdu_pkg::civil_t'(s_axis_tdata[37:0]);

    cdu_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .in_item   (in_item),
        .out_valid (dec_valid),
        .out_item  (dec_item)
    );

    cdu_days u_days
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dec_valid),
        .in_item   (dec_item),
        .out_valid (cnt_valid),
        .out_item  (cnt_item)
    );

    cdu_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cnt_valid),
        .in_item   (cnt_item),
        .out_valid (res_valid),
        .out_item  (res_item)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = res_item.secs;
    assign m_axis_tuser  = res_item.ok;

endmodule

@@ rtl/cdu_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdu_decode
// Stage 1: range and calendar checks, March-based year and day of year.
// ----------------------------------------------------------------------------
module cdu_decode
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  cdu_pkg::civil_t in_item,
    output logic            out_valid,
    output cdu_pkg::dec_t   out_item
);

    logic                           valid_reg;
    cdu_pkg::dec_t                  item_reg;
    cdu_pkg::dec_t                  item_next;
    logic                           leap;
    logic                           ok_year;
    logic                           ok_month;
    logic                           ok_day;
    logic                           ok_time;
    logic                           ok_limit;
    logic                           march_start;
    logic [cdu_pkg::YEAR_W-1:0]     my;
    logic [cdu_pkg::YEAR_W-1:0]     k_full;
    logic [cdu_pkg::STAMP_W-1:0]    stamp;

    always_comb
    begin
        ok_year  = (in_item.year >= cdu_pkg::YEAR_MIN) && (in_item.year <= cdu_pkg::YEAR_MAX);
        ok_month = (in_item.month >= cdu_pkg::MONTH_JAN) && (in_item.month <= cdu_pkg::MONTH_DEC);
        // only valid years matter here, where the century rule hits 2100 alone
        leap     = (in_item.year[1:0] == 2'b00) && (in_item.year != cdu_pkg::YEAR_NO_LEAP);
        ok_day   = (in_item.day != '0) &&
                   (in_item.day <= cdu_pkg::month_days(in_item.month, leap));
        ok_time  = (in_item.hour < cdu_pkg::HOURS_PER_DAY) &&
                   (in_item.minute < cdu_pkg::MINS_PER_HOUR) &&
                   (in_item.second < cdu_pkg::SECS_PER_MIN);
        stamp    = {in_item.month, in_item.day, in_item.hour, in_item.minute, in_item.second};
        ok_limit = (in_item.year != cdu_pkg::YEAR_MAX) || (stamp <= cdu_pkg::LIMIT_STAMP);

        march_start = (in_item.month <= cdu_pkg::MONTH_FEB);
        my          = in_item.year - {{(cdu_pkg::YEAR_W-1){1'b0}}, march_start};
        k_full      = my - cdu_pkg::BASE_YEAR;

        item_next.ok     = ok_year && ok_month && ok_day && ok_time && ok_limit;
        item_next.k      = k_full[cdu_pkg::K_W-1:0];
        item_next.doy    = cdu_pkg::month_offset(in_item.month)
                         + {{(cdu_pkg::DOY_W-cdu_pkg::DAY_W){1'b0}}, in_item.day}
                         - {{(cdu_pkg::DOY_W-1){1'b0}}, 1'b1};
        item_next.hour   = in_item.hour;
        item_next.minute = in_item.minute;
        item_next.second = in_item.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

`ifndef SYNTHESIS
    a_k_range : assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && item_reg.ok) |->
            (item_reg.k >= cdu_pkg::K_MIN && item_reg.k <= cdu_pkg::K_MAX))
        else $error("accepted date gives year offset out of range");
`endif

endmodule

@@ rtl/cdu_days.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdu_days
// Stage 2: day count since the epoch and seconds within the day.
// ----------------------------------------------------------------------------
module cdu_days
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  cdu_pkg::dec_t  in_item,
    output logic           out_valid,
    output cdu_pkg::cnt_t  out_item
);

    logic                         valid_reg;
    cdu_pkg::cnt_t                item_reg;
    cdu_pkg::cnt_t                item_next;
    logic [2:0]                   q100;
    logic                         q400;
    logic [cdu_pkg::SUM_W-1:0]    mul365;
    logic [cdu_pkg::SUM_W-1:0]    sum;

    always_comb
    begin
        // k below 512: quotients by 100 and 400 from threshold compares
        q100 = {2'b00, (in_item.k >= cdu_pkg::K_100)} + {2'b00, (in_item.k >= cdu_pkg::K_200)}
             + {2'b00, (in_item.k >= cdu_pkg::K_300)} + {2'b00, (in_item.k >= cdu_pkg::K_400)}
             + {2'b00, (in_item.k >= cdu_pkg::K_500)};
        q400 = (in_item.k >= cdu_pkg::K_400);

        mul365 = cdu_pkg::SUM_W'(in_item.k) * cdu_pkg::DAYS_PER_YEAR;
        sum    = mul365
               + cdu_pkg::SUM_W'(in_item.k[cdu_pkg::K_W-1:2])
               + cdu_pkg::SUM_W'(q400)
               + cdu_pkg::SUM_W'(in_item.doy)
               - cdu_pkg::SUM_W'(q100)
               - cdu_pkg::EPOCH_OFFSET;

        item_next.ok   = in_item.ok;
        item_next.days = sum[cdu_pkg::DAYS_W-1:0];
        item_next.tod  = cdu_pkg::TOD_W'(in_item.hour) * cdu_pkg::SECS_PER_HOUR
                       + cdu_pkg::TOD_W'(in_item.minute) * cdu_pkg::SECS_PER_MINUTE
                       + cdu_pkg::TOD_W'(in_item.second);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

`ifndef SYNTHESIS
    a_days_range : assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && item_reg.ok) |-> (item_reg.days <= cdu_pkg::DAYS_MAX))
        else $error("accepted date gives day count past 2106-02-07");
`endif

endmodule

@@ rtl/cdu_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdu_scale
// Stages 3 and 4: days times 86400, then add the time of day and zero the
// result of a rejected date.
// ----------------------------------------------------------------------------
module cdu_scale
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  cdu_pkg::cnt_t  in_item,
    output logic           out_valid,
    output cdu_pkg::res_t  out_item
);

    logic                          mul_valid_reg;
    logic                          mul_ok_reg;
    logic [cdu_pkg::SECS_W-1:0]    mul_secs_reg;
    logic [cdu_pkg::SECS_W-1:0]    mul_secs_next;
    logic [cdu_pkg::TOD_W-1:0]     mul_tod_reg;
    logic                          res_valid_reg;
    cdu_pkg::res_t                 res_reg;
    cdu_pkg::res_t                 res_next;

    always_comb
    begin
        mul_secs_next = cdu_pkg::SECS_W'(in_item.days) * cdu_pkg::SECS_PER_DAY;

        res_next.ok   = mul_ok_reg;
        res_next.secs = mul_ok_reg ? (mul_secs_reg + cdu_pkg::SECS_W'(mul_tod_reg)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_valid_reg <= in_valid;
            res_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_ok_reg   <= in_item.ok;
            mul_secs_reg <= mul_secs_next;
            mul_tod_reg  <= in_item.tod;
            res_reg      <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;

`ifndef SYNTHESIS
    a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.ok) |-> (res_reg.secs == '0))
        else $error("rejected date left a nonzero seconds count");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the civil date/time to Unix seconds converter.
// A short table of boundary dates runs first, followed by random dates that
// are mostly well formed with some near-edge and raw-noise items mixed in.
// Every output transfer is compared against the expected value, given in the
// table row or taken from an in-bench calendar predictor. Both stream sides idle at random outside the steady stretch.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_RANDOM = 1800;
    localparam int NUM_DIR    = 26;
    localparam int DRAIN_WAIT = 10;   // extra wait after the 4-stage pipeline has drained
    localparam int IDLE_PCT   = 13;

    // last moment that fits in 32 bits: 2106-02-07 06:28:15
    localparam logic [25:0] LAST_MOMENT = {4'd2, 5'd7, 5'd6, 6'd28, 6'd15};

    typedef struct {
        int unsigned year;
        int unsigned month;
        int unsigned day;
        int unsigned hour;
        int unsigned minute;
        int unsigned second;
        bit          typed;    // expected value given in the row
        bit          ok;
        logic [31:0] secs;
    } date_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
    // [31:26] minute, [37:32] second, [39:38] zero
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] unix_seconds
    logic [31:0] m_axis_tdata;
    // [0] valid_res
    logic        m_axis_tuser;

    cdu_pkg::res_t pending_stamps[$];
    int   mismatches = 0;
    int   n_accepted = 0;
    int   n_rejected = 0;
    bit   steady = 1'b0;           // no idling on either side while set

    date_row_t date_rows [NUM_DIR] = '{
        '{1970,  1,  1,  0,  0,  0, 1'b1, 1'b1, 32'd0},
        '{2106,  2,  7,  6, 28, 15, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{2106,  2,  7,  6, 28, 16, 1'b1, 1'b0, 32'd0},
        '{2106,  2,  7,  6, 29,  0, 1'b1, 1'b0, 32'd0},
        '{2106,  2,  7,  7,  0,  0, 1'b1, 1'b0, 32'd0},
        '{2106,  2,  8,  0,  0,  0, 1'b1, 1'b0, 32'd0},
        '{2106,  3,  1,  0,  0,  0, 1'b1, 1'b0, 32'd0},
        '{2106,  2,  6, 23, 59, 59, 1'b0, 1'b0, 32'd0},
        '{2106,  1, 31, 23, 59, 59, 1'b0, 1'b0, 32'd0},
        '{1969, 12, 31, 23, 59, 59, 1'b1, 1'b0, 32'd0},
        '{2107,  1,  1,  0,  0,  0, 1'b1, 1'b0, 32'd0},
        '{   0,  0,  0,  0,  0,  0, 1'b1, 1'b0, 32'd0},
        '{4095, 15, 31, 31, 63, 63, 1'b1, 1'b0, 32'd0},
        '{2000,  0,  1,  0,  0,  0, 1'b1, 1'b0, 32'd0},
        '{2000, 13,  1,  0,  0,  0, 1'b1, 1'b0, 32'd0},
        '{2000,  1,  0,  0,  0,  0, 1'b1, 1'b0, 32'd0},
        '{2000,  1,  1, 24,  0,  0, 1'b1, 1'b0, 32'd0},
        '{2000,  1,  1,  0, 60,  0, 1'b1, 1'b0, 32'd0},
        '{2000,  1,  1,  0,  0, 60, 1'b1, 1'b0, 32'd0},
        '{2001,  4, 31,  0,  0,  0, 1'b1, 1'b0, 32'd0},
        '{2001,  2, 29,  0,  0,  0, 1'b1, 1'b0, 32'd0},
        '{2000,  2, 29, 23, 59, 59, 1'b0, 1'b0, 32'd0},
        '{2000,  2, 30,  0,  0,  0, 1'b1, 1'b0, 32'd0},
        '{2100,  2, 29,  0,  0,  0, 1'b1, 1'b0, 32'd0},
        '{2038,  1, 19,  3, 14,  7, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{2104,  2, 29, 12,  0,  0, 1'b0, 1'b0, 32'd0}
    };

    civil_datetime_to_unix_seconds_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned days_in_month(logic [cdu_pkg::YEAR_W-1:0] yr,
                                                  logic [cdu_pkg::MONTH_W-1:0] mo);
        bit leap;
        leap = ((yr % 12'd4 == 12'd0) && (yr % 12'd100 != 12'd0)) ||
               (yr % 12'd400 == 12'd0);
        if (mo == cdu_pkg::MONTH_APR || mo == cdu_pkg::MONTH_JUN ||
            mo == cdu_pkg::MONTH_SEP || mo == cdu_pkg::MONTH_NOV)
            return 30;
        else if (mo == cdu_pkg::MONTH_FEB)
            return leap ? 29 : 28;
        else
            return 31;
    endfunction

    // days-from-civil with a March-based year; 719468 days from 0000-03-01
    function automatic cdu_pkg::res_t civil_to_epoch_secs(cdu_pkg::civil_t c);
        cdu_pkg::res_t r;
        bit     good;
        longint yr, era, yoe, mp, doy, doe, days, secs;
        good = (c.year >= 1970) && (c.year <= 2106) && (c.month >= 1) &&
               (c.month <= 12) && (c.day >= 1) && (c.hour < 24) &&
               (c.minute < 60) && (c.second < 60);
        if (good && 32'(c.day) > days_in_month(c.year, c.month))
            good = 1'b0;
        if (good && c.year == 2106 &&
            {c.month, c.day, c.hour, c.minute, c.second} > LAST_MOMENT)
            good = 1'b0;
        r.ok   = good;
        r.secs = '0;
        if (good)
        begin
            yr   = (c.month <= cdu_pkg::MONTH_FEB) ? longint'(c.year) - 1
                                                   : longint'(c.year);
            era  = yr / 400;
            yoe  = yr % 400;
            mp   = (c.month > cdu_pkg::MONTH_FEB) ? longint'(c.month) - 3
                                                  : longint'(c.month) + 9;
            doy  = (153 * mp + 2) / 5 + longint'(c.day) - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * 146097 + doe - 719468;
            secs = ((days * 24 + longint'(c.hour)) * 60 + longint'(c.minute)) * 60
                 + longint'(c.second);
            r.secs = secs[31:0];
        end
        return r;
    endfunction

    // one input transfer, with random idle cycles ahead of it unless steady is set
    task automatic push_conversion(cdu_pkg::civil_t c, cdu_pkg::res_t want);
        bit sent;
        sent = 1'b0;
        while (!sent)
        begin
            @(negedge clk);
            if (!steady && $urandom_range(0, 99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, c};
                @(posedge clk);
                while (!s_axis_tready)
                    @(posedge clk);
                pending_stamps.push_back(want);
                sent = 1'b1;
            end
        end
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_stamps.size() != 0)
            @(posedge clk);
    endtask

    function automatic cdu_pkg::civil_t random_date();
        cdu_pkg::civil_t c;
        int unsigned pick;
        int unsigned mlen;
        logic [63:0] noise;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            // raw noise over every bit of every field
            noise = {$urandom, $urandom};
            c     = noise[37:0];
        end
        else if (pick < 45)
        begin
            // near the edges of each field
            case ($urandom_range(0, 3))
                0: c.year = 12'd1970;
                1: c.year = 12'd2105;
                2: c.year = 12'd2106;
                default: c.year = cdu_pkg::YEAR_W'($urandom_range(1969, 2107));
            endcase
            c.month  = cdu_pkg::MONTH_W'(($urandom_range(0, 3) == 0) ?
                                         $urandom_range(0, 15) : $urandom_range(1, 12));
            mlen     = days_in_month(c.year, c.month);
            c.day    = cdu_pkg::DAY_W'($urandom_range(0, 1) ? mlen
                                                            : mlen + $urandom_range(0, 1));
            c.hour   = cdu_pkg::HOUR_W'($urandom_range(22, 24));
            c.minute = cdu_pkg::MINUTE_W'($urandom_range(58, 60));
            c.second = cdu_pkg::SECOND_W'($urandom_range(58, 60));
            if (c.year == 2106 && $urandom_range(0, 1))
            begin
                c.month  = cdu_pkg::MONTH_FEB;
                c.day    = cdu_pkg::DAY_W'($urandom_range(6, 8));
                c.hour   = cdu_pkg::HOUR_W'($urandom_range(5, 7));
                c.minute = cdu_pkg::MINUTE_W'($urandom_range(27, 29));
                c.second = cdu_pkg::SECOND_W'($urandom_range(14, 16));
            end
        end
        else
        begin
            c.year   = cdu_pkg::YEAR_W'($urandom_range(1970, 2106));
            c.month  = cdu_pkg::MONTH_W'($urandom_range(1, 12));
            c.day    = cdu_pkg::DAY_W'($urandom_range(1, days_in_month(c.year, c.month)));
            c.hour   = cdu_pkg::HOUR_W'($urandom_range(0, 23));
            c.minute = cdu_pkg::MINUTE_W'($urandom_range(0, 59));
            c.second = cdu_pkg::SECOND_W'($urandom_range(0, 59));
        end
        return c;
    endfunction

    // sink side: random back-pressure unless steady is set
    always @(negedge clk)
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        cdu_pkg::res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (m_axis_tuser)
                n_accepted++;
            else
                n_rejected++;
            if (pending_stamps.size() == 0)
            begin
                $error("unexpected output transfer: valid_res=%0b unix_seconds=%0d",
                       m_axis_tuser, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_stamps.pop_front();
                if (m_axis_tuser !== want.ok)
                begin
                    $error("valid_res: expected %0b, got %0b", want.ok, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata !== want.secs)
                begin
                    $error("unix_seconds: expected %0d, got %0d", want.secs, m_axis_tdata);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("civil_datetime_to_unix_seconds_core: mismatch");
        $finish;
    end

    initial
    begin
        cdu_pkg::civil_t c;
        cdu_pkg::res_t   want;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (date_rows[i])
        begin
            c.year   = cdu_pkg::YEAR_W'(date_rows[i].year);
            c.month  = cdu_pkg::MONTH_W'(date_rows[i].month);
            c.day    = cdu_pkg::DAY_W'(date_rows[i].day);
            c.hour   = cdu_pkg::HOUR_W'(date_rows[i].hour);
            c.minute = cdu_pkg::MINUTE_W'(date_rows[i].minute);
            c.second = cdu_pkg::SECOND_W'(date_rows[i].second);
            if (date_rows[i].typed)
            begin
                want.ok   = date_rows[i].ok;
                want.secs = date_rows[i].secs;
            end
            else
                want = civil_to_epoch_secs(c);
            push_conversion(c, want);
        end
        hold_until_drained();

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            steady = (n >= 600 && n < 1000);
            if (n == 1200)
                hold_until_drained();
            c = random_date();
            push_conversion(c, civil_to_epoch_secs(c));
        end
        steady = 1'b0;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        while (pending_stamps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d table rows and %0d random dates under random stalls.",
                 NUM_DIR, NUM_RANDOM);
        $display("Outputs seen: %0d accepted, %0d rejected, %0d field errors.",
                 n_accepted, n_rejected, mismatches);
        if (mismatches == 0 && pending_stamps.size() == 0)
            $display("civil_datetime_to_unix_seconds_core: match");
        else
            $display("civil_datetime_to_unix_seconds_core: mismatch");
        $finish;
    end

endmodule
